[hw/rtl/lcdw_pkg.sv]
// Shared types and constants for the LCD nibble writer.
package lcdw_pkg;

    localparam int COLUMNS = 16;
    localparam int ROWS    = 2;
    localparam int SLOTS   = ROWS * COLUMNS;
    localparam int SLOT_W  = $clog2(SLOTS);

    localparam logic [7:0] ADDR_ROW0  = 8'h80;
    localparam logic [7:0] ADDR_ROW1  = 8'hC0;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Input item opcodes
    typedef enum logic [1:0] {
        OP_DIFF = 2'd0,
        OP_CMD8 = 2'd1,
        OP_CMD4 = 2'd2,
        OP_DATA = 2'd3
    } op_t;

    // Nibble sequence kinds carried from front to back
    typedef enum logic [1:0] {
        SEQ_CMD8 = 2'd0,
        SEQ_CMD4 = 2'd1,
        SEQ_DATA = 2'd2,
        SEQ_SLOT = 2'd3
    } seq_kind_t;

    // One queued job: first byte, and second byte for slot updates
    typedef struct packed {
        seq_kind_t   kind;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
    } job_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic  head_valid;
        job_t  head;
    } q_head_t;

endpackage

[hw/rtl/lcdw_front.sv]
// Front end: accepts items, checks the shadow store and queues nibble jobs.
module lcdw_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          opcode,
    input  logic                row_sel,
    input  logic [3:0]          column,
    input  logic [7:0]          value,
    input  logic                q_full,
    output logic                push,
    output lcdw_pkg::job_t      push_job
);

    logic [7:0]                      shadow_reg [lcdw_pkg::SLOTS];
    logic                            accept;
    logic                            in_range;
    logic [lcdw_pkg::SLOT_W-1:0]     slot_idx;
    logic [7:0]                      char_val;
    logic [7:0]                      addr_byte;
    logic                            changed;
    logic                            shadow_we;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Locate the panel position and map a zero character to a space
    assign in_range  = (int'(row_sel) < lcdw_pkg::ROWS) && (int'(column) < lcdw_pkg::COLUMNS);
    assign slot_idx  = lcdw_pkg::SLOT_W'(int'(row_sel) * lcdw_pkg::COLUMNS + int'(column));
    assign char_val  = (value == 8'h00) ? lcdw_pkg::SPACE_CHAR : value;
    assign addr_byte = (row_sel ? lcdw_pkg::ADDR_ROW1 : lcdw_pkg::ADDR_ROW0) + {4'b0000, column};
    assign changed   = in_range && (shadow_reg[slot_idx] != char_val);

    // Classify the item into a job, or drop it
    always_comb
    begin
        push           = 1'b0;
        shadow_we      = 1'b0;
        push_job.kind  = lcdw_pkg::SEQ_CMD8;
        push_job.byte_a = value;
        push_job.byte_b = char_val;
        unique case (lcdw_pkg::op_t'(opcode))
            lcdw_pkg::OP_CMD8:
            begin
                push          = accept;
                push_job.kind = lcdw_pkg::SEQ_CMD8;
            end
            lcdw_pkg::OP_CMD4:
            begin
                push          = accept;
                push_job.kind = lcdw_pkg::SEQ_CMD4;
            end
            lcdw_pkg::OP_DATA:
            begin
                push          = accept;
                push_job.kind = lcdw_pkg::SEQ_DATA;
            end
            lcdw_pkg::OP_DIFF:
            begin
                push            = accept && changed;
                shadow_we       = accept && changed;
                push_job.kind   = lcdw_pkg::SEQ_SLOT;
                push_job.byte_a = addr_byte;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Update the shadow of the panel contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lcdw_pkg::SLOTS; i++)
            begin
                shadow_reg[i] <= 8'h00;
            end
        end
        else if (shadow_we)
        begin
            shadow_reg[slot_idx] <= char_val;
        end
    end

endmodule

[hw/rtl/lcdw_queue.sv]
// Two-entry job queue between front and back end.
module lcdw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lcdw_pkg::job_t      push_job,
    output logic                full,
    input  logic                pop,
    output lcdw_pkg::q_head_t   head
);

    lcdw_pkg::job_t  mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != 2'd0);

    assign head.head_valid = (count_reg != 2'd0);
    assign head.head       = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the job payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/lcdw_back.sv]
// Back end: serializes queued jobs into nibble transfers.
module lcdw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lcdw_pkg::q_head_t   head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                reg_select,
    output logic [3:0]          nibble,
    output logic                last
);

    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        valid_reg;
    logic        valid_next;
    logic        rs_reg;
    logic [3:0]  nib_reg;
    logic        last_reg;
    logic        load;
    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic [3:0]  cur_nib;
    logic        cur_last;

    // Pick the nibble at the current position of the head job
    assign cur_byte = idx_reg[1] ? head.head.byte_b : head.head.byte_a;
    assign cur_nib  = idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];

    always_comb
    begin
        cur_rs   = 1'b0;
        cur_last = 1'b0;
        unique case (head.head.kind)
            lcdw_pkg::SEQ_CMD4:
            begin
                cur_last = 1'b1;
            end
            lcdw_pkg::SEQ_CMD8:
            begin
                cur_last = idx_reg[0];
            end
            lcdw_pkg::SEQ_DATA:
            begin
                cur_rs   = 1'b1;
                cur_last = idx_reg[0];
            end
            lcdw_pkg::SEQ_SLOT:
            begin
                cur_rs   = idx_reg[1];
                cur_last = (idx_reg == 2'd3);
            end
            default:
            begin
                cur_last = 1'b1;
            end
        endcase
    end

    // Load the output register whenever it is free or being drained
    assign load = head.head_valid && (!valid_reg || !out_stall);
    assign pop  = load && cur_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = cur_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the nibble payload until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rs_reg   <= cur_rs;
            nib_reg  <= cur_nib;
            last_reg <= cur_last;
        end
    end

    assign out_valid  = valid_reg;
    assign reg_select = rs_reg;
    assign nibble     = nib_reg;
    assign last       = last_reg;

endmodule

[hw/rtl/lcd_diff_update_nibble_writer.sv]
// Top level: LCD diff-update nibble writer, front end, job queue and back end.
// An accepted item's job is queued, then its nibbles load into the output register.
// One nibble per cycle on the output while out_stall is low; a changed slot yields
// 4 nibbles, a raw byte 2, a 4-bit command 1; unchanged slots produce no output.
// The front accepts one item per cycle while the two-entry queue has room.
// Reset (rst_n, async low) empties the queue and output and clears the shadow to zero.
module lcd_diff_update_nibble_writer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic        row_sel,
    input  logic [3:0]  column,
    input  logic [7:0]  value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic        last
);

    logic               q_full;
    logic               push;
    lcdw_pkg::job_t     push_job;
    logic               pop;
    lcdw_pkg::q_head_t  head;

    lcdw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .row_sel  (row_sel),
        .column   (column),
        .value    (value),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    lcdw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    lcdw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reg_select (reg_select),
        .nibble     (nibble),
        .last       (last)
    );

endmodule

[tb/sv/tb_lcd_diff_update_nibble_writer.sv]
// Self-checking testbench for the LCD diff-update nibble writer.
`timescale 1ns / 100ps

module tb_lcd_diff_update_nibble_writer;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 50;

    // One nibble transfer on the LCD bus
    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic       closes;
    } bus_nibble_t;

    // Track the panel shadow and the nibbles the block still owes
    class lcd_bus_tracker;
        bus_nibble_t pending_nibbles[$];
        logic [7:0]  panel_shadow[lcdw_pkg::SLOTS];
        int          mismatches;
        int          checked;

        function new();
            foreach (panel_shadow[i])
                panel_shadow[i] = 8'h00;
            mismatches = 0;
            checked = 0;
        endfunction

        function void push_byte(logic rs, logic [7:0] b, logic closes);
            pending_nibbles.push_back('{rs, b[7:4], 1'b0});
            pending_nibbles.push_back('{rs, b[3:0], closes});
        endfunction

        // Predict the nibbles of one accepted item; return how many
        function int note_item(lcdw_pkg::op_t op, logic row, logic [3:0] col,
                               logic [7:0] val);
            logic [7:0] ch;
            logic [7:0] addr;
            int         slot;
            case (op)
                lcdw_pkg::OP_CMD8:
                begin
                    push_byte(1'b0, val, 1'b1);
                    return 2;
                end
                lcdw_pkg::OP_CMD4:
                begin
                    pending_nibbles.push_back('{1'b0, val[7:4], 1'b1});
                    return 1;
                end
                lcdw_pkg::OP_DATA:
                begin
                    push_byte(1'b1, val, 1'b1);
                    return 2;
                end
                default: ;
            endcase
            // Drop slots outside the panel
            if (int'(row) >= lcdw_pkg::ROWS || int'(col) >= lcdw_pkg::COLUMNS)
                return 0;
            ch = (val == 8'h00) ? lcdw_pkg::SPACE_CHAR : val;
            slot = int'(row) * lcdw_pkg::COLUMNS + int'(col);
            // Skip slots that already show this character
            if (panel_shadow[slot] == ch)
                return 0;
            addr = (row ? lcdw_pkg::ADDR_ROW1 : lcdw_pkg::ADDR_ROW0) + {4'h0, col};
            push_byte(1'b0, addr, 1'b0);
            push_byte(1'b1, ch, 1'b1);
            panel_shadow[slot] = ch;
            return 4;
        endfunction

        // Compare one accepted nibble with the oldest one owed
        function void check_nibble(logic rs, logic [3:0] nib, logic closes);
            bus_nibble_t want;
            bus_nibble_t got;
            got = '{rs, nib, closes};
            checked++;
            if (pending_nibbles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] nibble with none owed: rs=%0b nibble=%h last=%0b",
                             $realtime, rs, nib, closes);
                return;
            end
            want = pending_nibbles.pop_front();
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] mismatch: rs exp %0b got %0b, nibble exp %h got %h,",
                              " last exp %0b got %0b"},
                             $realtime, want.rs, rs, want.nib, nib, want.closes, closes);
            end
        endfunction

        function int owed();
            return pending_nibbles.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] opcode;
    logic       row_sel;
    logic [3:0] column;
    logic [7:0] value;
    logic       out_valid;
    logic       out_stall;
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;

    lcd_bus_tracker bus_track = new();

    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_off = 1'b0;
    int n_items = 0;
    int n_silent = 0;
    int quiet_cycles = 0;

    lcd_diff_update_nibble_writer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .row_sel    (row_sel),
        .column     (column),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reg_select (reg_select),
        .nibble     (nibble),
        .last       (last)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the output side at random, or hold it off entirely
    always @(negedge clk)
    begin
        out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
    end

    // Check every accepted nibble
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            bus_track.check_nibble(reg_select, nibble, last);
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one item, wait for it to be taken, then predict its nibbles
    task automatic send_item(input lcdw_pkg::op_t op, input logic row,
                             input logic [3:0] col, input logic [7:0] val);
        int produced;
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            opcode   <= op;
            row_sel  <= row;
            column   <= col;
            value    <= val;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            produced = bus_track.note_item(op, row, col, val);
            n_items++;
            if (produced == 0)
                n_silent++;
            @(negedge clk);
        end
    endtask

    // Build a random item; favor a few characters so slots often repeat
    task automatic send_random_item();
        int            pick;
        lcdw_pkg::op_t op;
        logic [7:0]    ch;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                op = lcdw_pkg::OP_DIFF;
            else if (pick < 70)
                op = lcdw_pkg::OP_CMD8;
            else if (pick < 85)
                op = lcdw_pkg::OP_CMD4;
            else
                op = lcdw_pkg::OP_DATA;
            case ($urandom_range(0, 9))
                0: ch = 8'h00;
                1: ch = lcdw_pkg::SPACE_CHAR;
                2: ch = 8'h41;
                3: ch = 8'h42;
                default: ch = 8'($urandom_range(0, 255));
            endcase
            send_item(op, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), ch);
        end
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall,
                             input int n_send);
        begin
            idle_pct = sender_idle;
            stall_pct = receiver_stall;
            repeat (n_send)
                send_random_item();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = lcdw_pkg::OP_DIFF;
        row_sel   = 1'b0;
        column    = 4'h0;
        value     = 8'h00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: first writes, unchanged slots, zero as space, raw extremes
        send_item(lcdw_pkg::OP_DIFF, 1'b0, 4'd0, 8'h00);
        send_item(lcdw_pkg::OP_DIFF, 1'b0, 4'd0, lcdw_pkg::SPACE_CHAR);
        send_item(lcdw_pkg::OP_DIFF, 1'b0, 4'd0, 8'h00);
        send_item(lcdw_pkg::OP_DIFF, 1'b1, 4'd15, 8'hFF);
        send_item(lcdw_pkg::OP_DIFF, 1'b1, 4'd15, 8'hFF);
        send_item(lcdw_pkg::OP_DIFF, 1'b1, 4'd15, 8'h00);
        send_item(lcdw_pkg::OP_DIFF, 1'b0, 4'd15, 8'h80);
        send_item(lcdw_pkg::OP_DIFF, 1'b1, 4'd0, 8'h7F);
        send_item(lcdw_pkg::OP_DIFF, 1'b0, 4'd7, lcdw_pkg::SPACE_CHAR);
        send_item(lcdw_pkg::OP_CMD8, 1'b1, 4'd15, 8'h00);
        send_item(lcdw_pkg::OP_CMD8, 1'b0, 4'd0, 8'hFF);
        send_item(lcdw_pkg::OP_CMD8, 1'b0, 4'd3, 8'h01);
        send_item(lcdw_pkg::OP_CMD4, 1'b0, 4'd0, 8'h30);
        send_item(lcdw_pkg::OP_CMD4, 1'b1, 4'd9, 8'hF0);
        send_item(lcdw_pkg::OP_CMD4, 1'b0, 4'd0, 8'h0F);
        send_item(lcdw_pkg::OP_DATA, 1'b0, 4'd0, 8'h00);
        send_item(lcdw_pkg::OP_DATA, 1'b1, 4'd15, 8'hFF);
        send_item(lcdw_pkg::OP_DATA, 1'b0, 4'd5, 8'h5A);
        send_item(lcdw_pkg::OP_DIFF, 1'b1, 4'd8, 8'hA5);
        send_item(lcdw_pkg::OP_DATA, 1'b1, 4'd8, 8'h41);
        send_item(lcdw_pkg::OP_CMD8, 1'b1, 4'd8, 8'h10);
        send_item(lcdw_pkg::OP_DIFF, 1'b1, 4'd8, 8'hA5);

        // Random: steady flow, sender gaps, receiver stalls, both
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(70, 0, PHASE_ITEMS);
        run_phase(0, 70, PHASE_ITEMS);
        run_phase(26, 26, PHASE_ITEMS);

        // Hold the receiver off while items keep coming, to fill the block
        fork
            begin
                @(posedge clk);
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            run_phase(0, 0, PHASE_ITEMS);
        join

        in_valid <= 1'b0;
        stall_pct = 0;
        while (bus_track.owed() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items (%0d left the panel unchanged) and %0d checked nibbles,",
                 n_items, n_silent, bus_track.checked);
        $display("with free flow, sender gaps, output stalls, both, and a long hold-off.");
        if (bus_track.mismatches == 0 && bus_track.owed() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches, %0d nibbles still owed",
                     bus_track.mismatches, bus_track.owed());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
